### src/aeo_pkg.sv
`timescale 1ns / 1ps

package aeo_pkg;

  localparam int BYTE_W    = 8;
  localparam int COUNT_W   = 32;
  localparam int DELTA_W   = COUNT_W + 1;
  localparam int SCALE_W   = 24;
  localparam int RESULT_W  = 58;
  localparam int CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORWARD_SCALE = 1'b0,
    REG_TURN_SCALE    = 1'b1
  } cfg_reg_t;

  // One finished read: both wheel deltas combined, or a timeout.
  typedef struct packed {
    logic                      valid;
    logic                      ok;
    logic signed [DELTA_W-1:0] sum;
    logic signed [DELTA_W-1:0] diff;
  } wheel_delta_t;

endpackage

### src/aeo_in_if.sv
`timescale 1ns / 1ps

interface aeo_in_if;
  import aeo_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              timed_out;

  modport source (output valid, output rx_byte, output timed_out, input ready);
  modport sink (input valid, input rx_byte, input timed_out, output ready);
endinterface

### src/aeo_out_if.sv
`timescale 1ns / 1ps

interface aeo_out_if;
  import aeo_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] forward_delta;
  logic signed [RESULT_W-1:0] heading_delta;
  logic                       read_ok;

  modport source (output valid, output forward_delta, output heading_delta, output read_ok,
                  input ready);
  modport sink (input valid, input forward_delta, input heading_delta, input read_ok,
                output ready);
endinterface

### src/aeo_parser.sv
`timescale 1ns / 1ps

module aeo_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [aeo_pkg::BYTE_W-1:0] rx_byte,
  input  logic                      timed_out,
  output aeo_pkg::wheel_delta_t     delta
);
  import aeo_pkg::*;

  logic [COUNT_W-1:0] number_accum;
  logic               minus_seen;
  logic               second_number;
  logic [COUNT_W-1:0] left_latched;
  logic [COUNT_W-1:0] prev_left;
  logic [COUNT_W-1:0] prev_right;

  logic               is_digit;
  logic               is_minus;
  logic               is_term;
  logic [COUNT_W-1:0] digit;
  logic [COUNT_W-1:0] number_accum_next;
  logic [COUNT_W-1:0] value;
  logic [COUNT_W-1:0] dl;
  logic [COUNT_W-1:0] dr;

  assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
  assign is_minus = (rx_byte == CHAR_MINUS);
  assign is_term  = (rx_byte == CHAR_NEWLINE) || (rx_byte == CHAR_SPACE);
  assign digit    = COUNT_W'(rx_byte - CHAR_ZERO);

  // Times ten as two shifts and an add.
  assign number_accum_next = (number_accum << 3) + (number_accum << 1) + digit;

  assign value = minus_seen ? (COUNT_W'(0) - number_accum) : number_accum;
  assign dl    = left_latched - prev_left;
  assign dr    = value - prev_right;

  always_comb begin
    delta.valid = 1'b0;
    delta.ok    = 1'b0;
    delta.sum   = '0;
    delta.diff  = '0;
    if (accept) begin
      if (timed_out) begin
        delta.valid = 1'b1;
      end else if (is_term && second_number) begin
        delta.valid = 1'b1;
        delta.ok    = 1'b1;
        delta.sum   = DELTA_W'(signed'(dl)) + DELTA_W'(signed'(dr));
        delta.diff  = DELTA_W'(signed'(dr)) - DELTA_W'(signed'(dl));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number_accum  <= '0;
      minus_seen    <= 1'b0;
      second_number <= 1'b0;
      left_latched  <= '0;
      prev_left     <= '0;
      prev_right    <= '0;
    end else if (accept) begin
      if (timed_out) begin
        number_accum  <= '0;
        minus_seen    <= 1'b0;
        second_number <= 1'b0;
      end else if (is_term) begin
        number_accum <= '0;
        minus_seen   <= 1'b0;
        if (!second_number) begin
          left_latched  <= value;
          second_number <= 1'b1;
        end else begin
          prev_left     <= left_latched;
          prev_right    <= value;
          second_number <= 1'b0;
        end
      end else if (is_minus) begin
        minus_seen <= 1'b1;
      end else if (is_digit) begin
        number_accum <= number_accum_next;
      end
    end
  end

endmodule

### src/ascii_encoder_odometry.sv
`timescale 1ns / 1ps

// Differential-drive odometry from an ASCII encoder report.
// The rx channel carries one received character per transaction, or a read
// timeout when timed_out is set. Two signed decimal counts, left then right,
// each closed by a newline or a space, make one read. The odo channel carries
// one transaction per read: forward and heading deltas in signed Q.16 with
// read_ok set, or zeros with read_ok clear after a timeout.
// The user must write the scale registers through wr_en, wr_index and wr_data
// only while no transaction is in flight; the block does not enforce this.
// A character is taken every cycle while rx ready is high. The result of a
// closing character or a timeout passes through the parser register and then
// the multiply and output register before it appears on odo.
// Reset clears the scales, the stored counts and the parse state, and empties
// both pipeline registers. When the receiver stalls, the output register
// holds its transaction and the middle register still takes one more; rx
// ready drops only while both are full and odo is not taken.
module ascii_encoder_odometry (
  input  logic                           clk,
  input  logic                           rst,
  aeo_in_if.sink                         rx,
  aeo_out_if.source                      odo,
  input  logic                           wr_en,
  input  logic [aeo_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [aeo_pkg::SCALE_W-1:0]    wr_data
);
  import aeo_pkg::*;

  logic [SCALE_W-1:0] forward_scale;
  logic [SCALE_W-1:0] turn_scale;

  wheel_delta_t parsed;

  logic                      a_valid;
  logic                      a_ok;
  logic signed [DELTA_W-1:0] a_sum;
  logic signed [DELTA_W-1:0] a_diff;

  logic                       out_valid;
  logic                       out_ok;
  logic signed [RESULT_W-1:0] out_forward;
  logic signed [RESULT_W-1:0] out_heading;

  logic                       out_free;
  logic                       a_free;
  logic signed [RESULT_W-1:0] forward_prod;
  logic signed [RESULT_W-1:0] heading_prod;

  assign out_free = !out_valid || odo.ready;
  assign a_free   = !a_valid || out_free;
  assign rx.ready = a_free;

  aeo_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (rx.valid && a_free),
    .rx_byte   (rx.rx_byte),
    .timed_out (rx.timed_out),
    .delta     (parsed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      forward_scale <= '0;
      turn_scale    <= '0;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_FORWARD_SCALE: forward_scale <= wr_data;
        REG_TURN_SCALE:    turn_scale    <= wr_data;
        default: ;
      endcase
    end
  end

  assign forward_prod = RESULT_W'(a_sum) * signed'(RESULT_W'(forward_scale));
  assign heading_prod = RESULT_W'(a_diff) * signed'(RESULT_W'(turn_scale));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= parsed.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free) begin
      a_ok   <= parsed.ok;
      a_sum  <= parsed.sum;
      a_diff <= parsed.diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_ok      <= a_ok;
      out_forward <= forward_prod;
      out_heading <= heading_prod;
    end
  end

  assign odo.valid         = out_valid;
  assign odo.read_ok       = out_ok;
  assign odo.forward_delta = out_forward;
  assign odo.heading_delta = out_heading;

endmodule

### src/aeo_checker.sv
`timescale 1ns / 1ps

module aeo_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              rx_valid,
  input logic                              rx_ready,
  input logic                              odo_valid,
  input logic                              odo_ready,
  input logic signed [aeo_pkg::RESULT_W-1:0] forward_delta,
  input logic signed [aeo_pkg::RESULT_W-1:0] heading_delta,
  input logic                              read_ok
);
  import aeo_pkg::*;

  // A timeout transaction carries zero deltas.
  assert property (@(posedge clk) disable iff (rst)
    (odo_valid && !read_ok) |-> (forward_delta == '0 && heading_delta == '0))
    else $error("timeout transaction with nonzero deltas");

  // The input side stalls only behind a stalled output.
  assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> (odo_valid && !odo_ready))
    else $error("rx stalled without an odo stall");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) rst |=> !odo_valid)
    else $error("odo valid right after reset");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    (odo_valid && !odo_ready) |=>
      (odo_valid && $stable(forward_delta) && $stable(heading_delta) && $stable(read_ok)))
    else $error("stalled odo transaction changed");

  // A result on an idle output comes from an rx transaction that went through the middle register.
  assert property (@(posedge clk) disable iff (rst)
    $rose(odo_valid) |-> $past(rx_valid && rx_ready, 2))
    else $error("odo transaction without source");

endmodule

bind ascii_encoder_odometry aeo_checker u_aeo_checker (
  .clk           (clk),
  .rst           (rst),
  .rx_valid      (rx.valid),
  .rx_ready      (rx.ready),
  .odo_valid     (odo.valid),
  .odo_ready     (odo.ready),
  .forward_delta (odo.forward_delta),
  .heading_delta (odo.heading_delta),
  .read_ok       (odo.read_ok)
);

### sim/ascii_encoder_odometry_tb.sv
`timescale 1ns / 1ps

module ascii_encoder_odometry_tb;
  import aeo_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 90;
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic signed [RESULT_W-1:0] fwd;
    logic signed [RESULT_W-1:0] hdg;
    logic                       ok;
  } odo_read_t;

  class odometry_scoreboard;
    bit [SCALE_W-1:0] fwd_scale;
    bit [SCALE_W-1:0] turn_scale;
    bit [COUNT_W-1:0] accum;
    bit [COUNT_W-1:0] left_count;
    bit [COUNT_W-1:0] prev_left;
    bit [COUNT_W-1:0] prev_right;
    bit               minus;
    bit               on_right;
    odo_read_t        pending_reads[$];
    int               errors;
    int               good_reads;
    int               timeouts;

    function void set_scale(cfg_reg_t idx, bit [SCALE_W-1:0] value);
      if (idx == REG_FORWARD_SCALE) fwd_scale = value;
      else turn_scale = value;
    endfunction

    function void note_rx(bit [BYTE_W-1:0] ch, bit tmo);
      odo_read_t        r;
      bit [COUNT_W-1:0] count;
      int               d_left;
      int               d_right;
      longint           sum;
      longint           diff;
      if (tmo) begin
        accum = '0;
        minus = 1'b0;
        on_right = 1'b0;
        r.fwd = '0;
        r.hdg = '0;
        r.ok = 1'b0;
        pending_reads.push_back(r);
        return;
      end
      if (ch == CHAR_MINUS) minus = 1'b1;
      else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
        accum = accum * 32'd10 + COUNT_W'(ch - CHAR_ZERO);
      end
      if (ch != CHAR_NEWLINE && ch != CHAR_SPACE) return;
      count = minus ? -accum : accum;
      accum = '0;
      minus = 1'b0;
      if (!on_right) begin
        left_count = count;
        on_right = 1'b1;
        return;
      end
      d_left = left_count - prev_left;
      d_right = count - prev_right;
      sum = longint'(d_left) + longint'(d_right);
      diff = longint'(d_right) - longint'(d_left);
      r.fwd = RESULT_W'(sum * longint'(fwd_scale));
      r.hdg = RESULT_W'(diff * longint'(turn_scale));
      r.ok = 1'b1;
      prev_left = left_count;
      prev_right = count;
      on_right = 1'b0;
      pending_reads.push_back(r);
    endfunction

    function void check_odo(logic signed [RESULT_W-1:0] fwd, logic signed [RESULT_W-1:0] hdg,
                            logic ok);
      odo_read_t exp_read;
      if (pending_reads.size() == 0) begin
        $error("odo transaction with no read pending: forward_delta %0d", fwd);
        errors++;
        return;
      end
      exp_read = pending_reads.pop_front();
      if (fwd !== exp_read.fwd) begin
        $error("forward_delta: expected %0d, got %0d", exp_read.fwd, fwd);
        errors++;
      end
      if (hdg !== exp_read.hdg) begin
        $error("heading_delta: expected %0d, got %0d", exp_read.hdg, hdg);
        errors++;
      end
      if (ok !== exp_read.ok) begin
        $error("read_ok: expected %0b, got %0b", exp_read.ok, ok);
        errors++;
      end
      if (exp_read.ok) good_reads++;
      else timeouts++;
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [SCALE_W-1:0]   wr_data;

  aeo_in_if  rx_ch ();
  aeo_out_if odo_ch ();

  odometry_scoreboard sb = new();

  int burst_left;
  int counted_items;
  int scale_settings;
  int cycles;
  logic [15:0] stall_pat = 16'hFFFF;
  int pat_age;

  ascii_encoder_odometry DUT (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx_ch),
    .odo      (odo_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ascii_encoder_odometry_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (odo_ch.valid === 1'b1 && odo_ch.ready === 1'b1) begin
      sb.check_odo(odo_ch.forward_delta, odo_ch.heading_delta, odo_ch.read_ok);
    end
    if (pat_age == 0) begin
      pat_age = $urandom_range(40, 150);
      case ($urandom_range(0, 3))
        0: stall_pat = 16'hFFFF;
        1: stall_pat = 16'($urandom) | 16'h0001;
        2: stall_pat = 16'h8001;
        default: stall_pat = 16'($urandom & $urandom) | 16'h0100;
      endcase
    end else begin
      pat_age--;
    end
    odo_ch.ready <= stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[15:1]};
  end

  task automatic send_item(input logic [BYTE_W-1:0] ch, input logic tmo);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= ch;
    rx_ch.timed_out <= tmo;
    @(posedge clk);
    while (rx_ch.ready !== 1'b1) @(posedge clk);
    sb.note_rx(ch, tmo);
    burst_left--;
    if (tmo || ch == CHAR_MINUS || ch == CHAR_SPACE || ch == CHAR_NEWLINE ||
        (ch >= CHAR_ZERO && ch <= CHAR_NINE)) begin
      counted_items++;
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic logic [BYTE_W-1:0] noise_byte();
    logic [BYTE_W-1:0] ch;
    do begin
      ch = BYTE_W'($urandom_range(0, 255));
    end while (ch == CHAR_MINUS || ch == CHAR_SPACE || ch == CHAR_NEWLINE ||
               (ch >= CHAR_ZERO && ch <= CHAR_NINE));
    return ch;
  endfunction

  // Sends one count with a random number of digits, an optional minus sign at
  // a random place, occasional ignored characters, and a random terminator.
  task automatic send_count();
    int ndig;
    int pick;
    int minus_at;
    bit neg;
    pick = $urandom_range(0, 9);
    if (pick == 0) ndig = 0;
    else if (pick <= 6) ndig = $urandom_range(1, 4);
    else if (pick <= 8) ndig = $urandom_range(5, 9);
    else ndig = $urandom_range(10, 12);
    neg = ($urandom_range(0, 2) == 0);
    minus_at = $urandom_range(0, ndig);
    for (int i = 0; i <= ndig; i++) begin
      if (neg && i == minus_at) send_item(CHAR_MINUS, 1'b0);
      if ($urandom_range(0, 15) == 0) send_item(noise_byte(), 1'b0);
      if (i < ndig) send_item(CHAR_ZERO + BYTE_W'($urandom_range(0, 9)), 1'b0);
    end
    send_item($urandom_range(0, 1) ? CHAR_SPACE : CHAR_NEWLINE, 1'b0);
  endtask

  task automatic settle();
    rx_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scales(input logic [SCALE_W-1:0] fwd, input logic [SCALE_W-1:0] turn);
    wr_en <= 1'b1;
    wr_index <= REG_FORWARD_SCALE;
    wr_data <= fwd;
    @(posedge clk);
    wr_index <= REG_TURN_SCALE;
    wr_data <= turn;
    @(posedge clk);
    wr_en <= 1'b0;
    sb.set_scale(REG_FORWARD_SCALE, fwd);
    sb.set_scale(REG_TURN_SCALE, turn);
    scale_settings++;
  endtask

  initial begin
    logic [SCALE_W-1:0] phase_fwd;
    logic [SCALE_W-1:0] phase_turn;
    int phase_end;
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= REG_FORWARD_SCALE;
    wr_data <= '0;
    rx_ch.valid <= 1'b0;
    rx_ch.rx_byte <= '0;
    rx_ch.timed_out <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_scales(24'h010000, 24'h00C000);

    send_text("5 -3\n");
    send_text("7");
    send_item(8'hFF, 1'b1);
    send_text(" \n");
    send_text("8000000000 ");
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_text("\n");
    send_item(CHAR_NEWLINE, 1'b1);

    for (int phase = 0; phase < 5; phase++) begin
      settle();
      case (phase)
        0: begin phase_fwd = 24'hFFFFFF; phase_turn = 24'hFFFFFF; end
        1: begin phase_fwd = 24'h000000; phase_turn = SCALE_W'($urandom); end
        2: begin phase_fwd = SCALE_W'($urandom); phase_turn = 24'h000000; end
        3: begin phase_fwd = 24'h000001; phase_turn = 24'hFFFFFF; end
        default: begin phase_fwd = SCALE_W'($urandom); phase_turn = SCALE_W'($urandom); end
      endcase
      write_scales(phase_fwd, phase_turn);
      phase_end = counted_items + PHASE_ITEMS;
      while (counted_items < phase_end) begin
        case ($urandom_range(0, 19))
          0: send_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
          1: begin
            send_count();
            send_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
          end
          2: repeat ($urandom_range(1, 3)) send_item(noise_byte(), 1'b0);
          3: send_item(BYTE_W'($urandom_range(0, 255)), 1'b0);
          default: begin
            send_count();
            send_count();
          end
        endcase
      end
    end

    settle();
    $display("Checked %0d good reads and %0d timeouts over %0d scale settings.",
             sb.good_reads, sb.timeouts, scale_settings);
    if (sb.errors == 0) begin
      $display("ascii_encoder_odometry_tb: clean");
    end else begin
      $display("ascii_encoder_odometry_tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
src/aeo_pkg.sv
src/aeo_in_if.sv
src/aeo_out_if.sv
src/aeo_parser.sv
src/ascii_encoder_odometry.sv
src/aeo_checker.sv
sim/ascii_encoder_odometry_tb.sv
